>>> design/h264fua_pkg.sv
// ----------------------------------------------------------------------------
// h264fua_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package h264fua_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65536;
    localparam int OP_QUEUE_DEPTH      = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_PAYLOAD    = 2'd0;
    localparam logic [1:0] CFG_TIMESTAMP_STEP = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_TYPE   = 2'd2;

    localparam logic [11:0] MAX_PAYLOAD_RST    = 12'd1400;
    localparam logic [16:0] TIMESTAMP_STEP_RST = 17'd9000;
    localparam logic [6:0]  PAYLOAD_TYPE_RST   = 7'd96;

    localparam logic [11:0] PAYLOAD_MIN = 12'd3;
    localparam logic [11:0] PAYLOAD_MAX = 12'd2048;
    localparam logic [4:0]  FU_A_TYPE   = 5'd28;
    localparam logic [4:0]  NAL_TYPE_LO = 5'd1;
    localparam logic [4:0]  NAL_TYPE_HI = 5'd23;
    localparam logic [23:0] START_CODE  = 24'h000001;
    localparam logic [23:0] WINDOW_RST  = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [16:0] frame_bytes;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        packet_end;
        logic        marker;
        logic [31:0] timestamp;
        logic [6:0]  rtp_payload_type;
        logic        last_of_run;
    } t_out_item;

    // one queued emit operation: a payload byte, optionally preceded by the
    // FU indicator and FU header
    typedef struct packed {
        logic [7:0]  data;
        logic        pkt_end;
        logic        marker;
        logic        frag_start;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [31:0] ts;
    } t_op;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_SINGLE = 3'b010,
        PH_FRAG   = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        SLOT_IND  = 3'b001,
        SLOT_HDR  = 3'b010,
        SLOT_DATA = 3'b100
    } t_slot;

endpackage

>>> design/h264_rtp_fu_a_packetizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// H.264 RTP packetizer: single NAL unit packets and FU-A fragmentation.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the operation queue is not full and emits
// RTP payload bytes, one output item per cycle while the output is ready. Most
// bytes give zero or one item and pass at full rate; the first payload byte of
// each FU-A fragment gives three items (FU indicator, FU header, byte). A queue
// of QUEUE_DEPTH operations sits between the byte classifier and the output
// expander, so input keeps flowing while fragment headers go out and while the
// output is stalled; the two header items of each fragment hold the sustained
// input rate below one byte per cycle. Configuration registers are always ready;
// max_payload and timestamp_step apply from the next byte, payload_type to each
// item as it leaves, so the user must write registers only with no item in flight; the block does not enforce it.
module h264_rtp_fu_a_packetizer
    import h264fua_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH     = OP_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    logic [11:0] r_max_payload;
    logic [16:0] r_ts_step;
    logic [6:0]  r_payload_type;

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_op         front_op;
    t_op         queue_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload  <= MAX_PAYLOAD_RST;
            r_ts_step      <= TIMESTAMP_STEP_RST;
            r_payload_type <= PAYLOAD_TYPE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_PAYLOAD:    r_max_payload  <= i_cfg_data[11:0];
                CFG_TIMESTAMP_STEP: r_ts_step      <= i_cfg_data;
                CFG_PAYLOAD_TYPE:   r_payload_type <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    h264fua_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_data        (i_in_data),
        .i_max_payload (r_max_payload),
        .i_ts_step     (r_ts_step),
        .o_push        (push),
        .o_op          (front_op),
        .i_full        (full)
    );

    h264fua_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_empty (empty)
    );

    h264fua_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (queue_op),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_payload_type (r_payload_type),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_data         (o_out_data)
    );

endmodule

>>> design/h264fua_front.sv
// ----------------------------------------------------------------------------
// h264fua_front
// Start code search and packet/fragment bookkeeping; one byte per cycle while
// the queue is not full, pushes one emit operation per byte that produces output.
// ----------------------------------------------------------------------------
module h264fua_front
    import h264fua_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    input  logic [11:0] i_max_payload,
    input  logic [16:0] i_ts_step,
    output logic        o_push,
    output t_op         o_op,
    input  logic        i_full
);

    localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = (LW < 17) ? LW : 17;
    localparam int EW = (LW > 17) ? LW : 17;
    localparam int XW = (CW + 1 > 12) ? CW + 1 : 12;

    t_phase         r_phase,  n_phase;
    logic [CW-1:0]  r_pos,    n_pos;
    logic [23:0]    r_win,    n_win;
    logic [CW-1:0]  r_remain, n_remain;
    logic [10:0]    r_fill,   n_fill;
    logic           r_first,  n_first;
    logic [7:0]     r_hdr,    n_hdr;
    logic [31:0]    r_ts,     n_ts;

    logic           accept;
    logic [EW-1:0]  fb_ext;
    logic [CW-1:0]  fbc;
    logic [11:0]    mp;
    logic [10:0]    chunk;
    logic [CW-1:0]  len;
    logic [CW-1:0]  rem_dec;
    logic [10:0]    fill_inc;
    logic [4:0]     nal_type;
    logic           found;
    logic           frag_last;
    logic           frag_end;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        fb_ext = EW'(i_data.frame_bytes);
        if (fb_ext == '0) begin
            fb_ext = EW'(1);
        end
        if (fb_ext > EW'(MAX_FRAME_BYTES)) begin
            fb_ext = EW'(MAX_FRAME_BYTES);
        end
        fbc = fb_ext[CW-1:0];

        mp = i_max_payload;
        if (mp < PAYLOAD_MIN) begin
            mp = PAYLOAD_MIN;
        end
        if (mp > PAYLOAD_MAX) begin
            mp = PAYLOAD_MAX;
        end
    end

    assign chunk    = 11'(mp - 12'd2);
    assign len      = fbc - r_pos;
    assign rem_dec  = r_remain - CW'(1);
    assign fill_inc = r_fill + 11'd1;
    assign nal_type = i_data.data_byte[4:0];
    assign found    = (r_win == START_CODE) && (nal_type >= NAL_TYPE_LO)
                      && (nal_type <= NAL_TYPE_HI)
                      && (XW'(fbc) >= XW'(r_pos) + XW'(2));
    // remaining + fill stays constant across a fragment
    assign frag_last = (XW'(r_remain) + XW'(r_fill)) <= XW'(chunk);
    assign frag_end  = (fill_inc >= chunk) || (rem_dec == '0);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_win    = r_win;
        n_remain = r_remain;
        n_fill   = r_fill;
        n_first  = r_first;
        n_hdr    = r_hdr;
        n_ts     = r_ts;
        o_push   = 1'b0;
        o_op.data       = i_data.data_byte;
        o_op.pkt_end    = 1'b0;
        o_op.marker     = 1'b1;
        o_op.frag_start = 1'b0;
        o_op.fu_ind     = {r_hdr[7:5], FU_A_TYPE};
        // FU header: S, E, reserved zero, NAL type
        o_op.fu_hdr     = {r_first, frag_last, 1'b0, r_hdr[4:0]};
        o_op.ts         = r_ts;

        if (accept) begin
            case (r_phase)
                PH_SINGLE: begin
                    if (r_remain != '0) begin
                        o_push       = 1'b1;
                        o_op.pkt_end = (rem_dec == '0);
                        n_remain     = rem_dec;
                    end
                    if (r_remain == '0 || rem_dec == '0) begin
                        n_phase  = PH_SEARCH;
                        n_pos    = '0;
                        n_win    = WINDOW_RST;
                        n_remain = '0;
                        n_fill   = '0;
                        n_first  = 1'b1;
                        n_ts     = r_ts + 32'(i_ts_step);
                    end
                end
                PH_FRAG: begin
                    if (r_remain != '0) begin
                        o_push          = 1'b1;
                        o_op.pkt_end    = frag_end;
                        o_op.marker     = frag_last;
                        o_op.frag_start = (r_fill == '0);
                        n_remain        = rem_dec;
                        n_fill          = frag_end ? 11'd0 : fill_inc;
                        n_first         = frag_end ? 1'b0 : r_first;
                    end
                    if (r_remain == '0 || rem_dec == '0) begin
                        n_phase  = PH_SEARCH;
                        n_pos    = '0;
                        n_win    = WINDOW_RST;
                        n_remain = '0;
                        n_fill   = '0;
                        n_first  = 1'b1;
                        n_ts     = r_ts + 32'(i_ts_step);
                    end
                end
                default: begin
                    if (found) begin
                        n_hdr    = i_data.data_byte;
                        n_remain = len - CW'(1);
                        n_win    = WINDOW_RST;
                        n_pos    = r_pos + CW'(1);
                        if (XW'(len) <= XW'(mp)) begin
                            n_phase = PH_SINGLE;
                            o_push  = 1'b1;
                        end else begin
                            n_phase = PH_FRAG;
                            n_fill  = '0;
                            n_first = 1'b1;
                        end
                    end else begin
                        n_win = {r_win[15:0], i_data.data_byte};
                        if (XW'(r_pos) + XW'(1) >= XW'(fbc)) begin
                            // no start code in this frame
                            n_phase  = PH_SEARCH;
                            n_pos    = '0;
                            n_win    = WINDOW_RST;
                            n_remain = '0;
                            n_fill   = '0;
                            n_first  = 1'b1;
                            n_ts     = r_ts + 32'(i_ts_step);
                        end else begin
                            n_pos = r_pos + CW'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEARCH;
            r_pos    <= '0;
            r_win    <= WINDOW_RST;
            r_remain <= '0;
            r_fill   <= '0;
            r_first  <= 1'b1;
            r_hdr    <= '0;
            r_ts     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_win    <= n_win;
            r_remain <= n_remain;
            r_fill   <= n_fill;
            r_first  <= n_first;
            r_hdr    <= n_hdr;
            r_ts     <= n_ts;
        end
    end

endmodule

>>> design/h264fua_fifo.sv
// ----------------------------------------------------------------------------
// h264fua_fifo
// Short register queue of emit operations between front and back.
// ----------------------------------------------------------------------------
module h264fua_fifo
    import h264fua_pkg::*;
#(
    parameter int DEPTH = OP_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_op            r_mem [DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [NW-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

>>> design/h264fua_back.sv
// ----------------------------------------------------------------------------
// h264fua_back
// Expands queued operations into output items: one item, or three for the
// first byte of an FU-A fragment (indicator, header, payload byte).
// ----------------------------------------------------------------------------
module h264fua_back
    import h264fua_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic        i_empty,
    output logic        o_pop,
    input  logic [6:0]  i_payload_type,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data
);

    logic   r_busy, n_busy;
    t_op    r_op;
    t_slot  r_slot, n_slot;
    logic   fire;
    logic   done;

    assign fire  = r_busy && i_ready;
    assign done  = fire && (r_slot == SLOT_DATA);
    assign o_pop = !i_empty && (!r_busy || done);

    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        if (o_pop) begin
            n_busy = 1'b1;
            n_slot = i_op.frag_start ? SLOT_IND : SLOT_DATA;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (fire) begin
            n_slot = (r_slot == SLOT_IND) ? SLOT_HDR : SLOT_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= SLOT_DATA;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_op;
        end
    end

    assign o_valid = r_busy;

    always_comb begin
        case (r_slot)
            SLOT_IND: o_data.packet_byte = r_op.fu_ind;
            SLOT_HDR: o_data.packet_byte = r_op.fu_hdr;
            default:  o_data.packet_byte = r_op.data;
        endcase
        o_data.packet_end       = (r_slot == SLOT_DATA) && r_op.pkt_end;
        o_data.marker           = r_op.marker;
        o_data.timestamp        = r_op.ts;
        o_data.rtp_payload_type = i_payload_type;
        o_data.last_of_run      = (r_slot == SLOT_DATA);
    end

endmodule

>>> verif/rtp_packet_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_packet_checker
// Watches the byte, packet and register channels of the FU-A packetizer,
// predicts the RTP payload items that each accepted frame byte must produce
// and compares them, field by field and in order, with the accepted output.
// ----------------------------------------------------------------------------
module rtp_packet_checker
    import h264fua_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);

    // register copies
    logic [11:0] max_pay;
    logic [16:0] ts_step;
    logic [6:0]  pt_reg;

    // packetizer state
    logic [16:0] pos_q;
    logic [23:0] win_q;
    t_phase      phase_q;
    logic [16:0] nal_left;
    logic [10:0] frag_fill;
    logic        first_frag;
    logic [7:0]  nal_hdr;
    logic [31:0] ts_now;

    t_out_item   due_items [$];
    t_out_item   want;
    int          err_count = 0;

    task automatic reset_model();
        max_pay    = MAX_PAYLOAD_RST;
        ts_step    = TIMESTAMP_STEP_RST;
        pt_reg     = PAYLOAD_TYPE_RST;
        pos_q      = '0;
        win_q      = WINDOW_RST;
        phase_q    = PH_SEARCH;
        nal_left   = '0;
        frag_fill  = '0;
        first_frag = 1'b1;
        nal_hdr    = '0;
        ts_now     = '0;
    endtask

    task automatic close_frame();
        pos_q      = '0;
        win_q      = WINDOW_RST;
        phase_q    = PH_SEARCH;
        nal_left   = '0;
        frag_fill  = '0;
        first_frag = 1'b1;
        ts_now     = ts_now + ts_step;
    endtask

    function automatic t_out_item make_item(input logic [7:0] b, input logic e,
                                            input logic mk);
        t_out_item r;
        r.packet_byte      = b;
        r.packet_end       = e;
        r.marker           = mk;
        r.timestamp        = ts_now;
        r.rtp_payload_type = pt_reg;
        r.last_of_run      = 1'b0;
        return r;
    endfunction

    task automatic packetize_byte(input t_in_item item);
        t_out_item   run_r [3];
        int          n;
        int unsigned fb, mp, chunk, len;
        logic        tail, pkt_done;
        n  = 0;
        fb = item.frame_bytes;
        if (fb == 0) fb = 1;
        if (fb > MAX_FRAME_BYTES_DEF) fb = MAX_FRAME_BYTES_DEF;
        mp = max_pay;
        if (mp < PAYLOAD_MIN) mp = PAYLOAD_MIN;
        if (mp > PAYLOAD_MAX) mp = PAYLOAD_MAX;
        chunk = mp - 2;

        case (phase_q)
            PH_SINGLE: begin
                if (nal_left == 0) begin
                    close_frame();
                end else begin
                    nal_left--;
                    run_r[n] = make_item(item.data_byte, nal_left == 0, 1'b1);
                    n++;
                    pos_q++;
                    if (nal_left == 0) close_frame();
                end
            end
            PH_FRAG: begin
                if (nal_left == 0) begin
                    close_frame();
                end else begin
                    // marker goes on every item of the fragment that ends the unit
                    tail = (nal_left + frag_fill <= chunk);
                    if (frag_fill == 0) begin
                        run_r[n] = make_item({nal_hdr[7:5], FU_A_TYPE}, 1'b0, tail);
                        n++;
                        run_r[n] = make_item({first_frag, tail, 1'b0, nal_hdr[4:0]},
                                             1'b0, tail);
                        n++;
                    end
                    nal_left--;
                    frag_fill++;
                    pkt_done = (frag_fill >= chunk) || (nal_left == 0);
                    run_r[n] = make_item(item.data_byte, pkt_done, tail);
                    n++;
                    if (pkt_done) begin
                        frag_fill  = '0;
                        first_frag = 1'b0;
                    end
                    pos_q++;
                    if (nal_left == 0) close_frame();
                end
            end
            default: begin
                if (win_q == START_CODE && item.data_byte[4:0] >= NAL_TYPE_LO
                        && item.data_byte[4:0] <= NAL_TYPE_HI && fb >= pos_q + 2) begin
                    len      = fb - pos_q;
                    nal_hdr  = item.data_byte;
                    nal_left = 17'(len - 1);
                    win_q    = WINDOW_RST;
                    pos_q++;
                    if (len <= mp) begin
                        phase_q  = PH_SINGLE;
                        run_r[n] = make_item(item.data_byte, 1'b0, 1'b1);
                        n++;
                    end else begin
                        // header byte is folded into the FU indicator/header
                        phase_q    = PH_FRAG;
                        frag_fill  = '0;
                        first_frag = 1'b1;
                    end
                end else begin
                    win_q = {win_q[15:0], item.data_byte};
                    if (pos_q + 1 >= fb) close_frame();
                    else pos_q++;
                end
            end
        endcase

        if (n > 0) begin
            run_r[n-1].last_of_run = 1'b1;
            for (int k = 0; k < n; k++) due_items.push_back(run_r[k]);
        end
    endtask

    function automatic void check_field(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            due_items.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_PAYLOAD:    max_pay = i_cfg_data[11:0];
                    CFG_TIMESTAMP_STEP: ts_step = i_cfg_data;
                    CFG_PAYLOAD_TYPE:   pt_reg  = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) packetize_byte(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (due_items.size() == 0) begin
                    $display("%0t: item expected none, actual 0x%0h", $time, i_out_data);
                    err_count++;
                end else begin
                    want = due_items.pop_front();
                    check_field("packet_byte", want.packet_byte, i_out_data.packet_byte);
                    check_field("packet_end", want.packet_end, i_out_data.packet_end);
                    check_field("marker", want.marker, i_out_data.marker);
                    check_field("timestamp", want.timestamp, i_out_data.timestamp);
                    check_field("rtp_payload_type", want.rtp_payload_type,
                                i_out_data.rtp_payload_type);
                    check_field("last_of_run", want.last_of_run, i_out_data.last_of_run);
                end
            end
        end
        o_pending <= due_items.size();
        o_errors  <= err_count;
    end

endmodule

>>> verif/tb_h264_rtp_fu_a_packetizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_h264_rtp_fu_a_packetizer
// Drives encoded frames into the packetizer: a few hand-built frames, then
// random frames with valid, missing, false and truncated start codes under
// several register settings, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_h264_rtp_fu_a_packetizer;
    import h264fua_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_OFF     = 16;
    localparam int ITEMS_TOTAL  = 410;
    localparam int NUM_PHASES   = 10;
    localparam int FB_FIELD_MAX = 131071;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_MAX_PAYLOAD;
    logic [16:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic        o_cfg_ready;

    int          pending;
    int          mismatches;
    int unsigned cycle_cnt  = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          mp_eff     = MAX_PAYLOAD_RST;

    logic [7:0]  fr [$];
    int          hdr_at;

    always #10 i_clk = ~i_clk;

    h264_rtp_fu_a_packetizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rtp_packet_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (mismatches)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output side: ready stretches broken by short and occasional long stalls
    initial begin
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat (($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24))
                @(posedge i_clk);
            i_out_ready <= 1'b0;
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 16)
                                                : $urandom_range(1, 3))
                @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [16:0] fb);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_in_item'{data_byte: b, frame_bytes: fb};
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        items_sent++;
    endtask

    // stop sending until every predicted item has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_regs(input int mp_raw, input int step, input int ptype);
        logic [1:0] idx [3];
        int         val [3];
        idx[0] = CFG_MAX_PAYLOAD;
        idx[1] = CFG_TIMESTAMP_STEP;
        idx[2] = CFG_PAYLOAD_TYPE;
        val[0] = mp_raw;
        val[1] = step;
        val[2] = ptype;
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= 17'(val[k]);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        if (mp_raw < PAYLOAD_MIN) mp_eff = PAYLOAD_MIN;
        else if (mp_raw > PAYLOAD_MAX) mp_eff = PAYLOAD_MAX;
        else mp_eff = mp_raw;
    endtask

    task automatic load_hex(input logic [127:0] v, input int n, input int hdr);
        fr.delete();
        for (int k = n - 1; k >= 0; k--) fr.push_back(v[8*k +: 8]);
        hdr_at = hdr;
    endtask

    // filler that never contains 01, so no start code forms by accident
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        if (b == 8'h01) b = 8'h02;
        return b;
    endfunction

    function automatic void push_start_code();
        fr.push_back(8'h00);
        fr.push_back(8'h00);
        fr.push_back(8'h01);
    endfunction

    task automatic random_frame();
        int         kind, nal_len, hi, n, t;
        logic [7:0] hdr;
        fr.delete();
        hdr_at = -1;
        kind = $urandom_range(0, 19);
        n = $urandom_range(0, 3);
        repeat (n) fr.push_back(junk_byte());
        if ($urandom_range(0, 3) == 0) begin
            // start code followed by a type the block must skip
            t = $urandom_range(23, 31);
            if (t == 23) t = 0;
            push_start_code();
            fr.push_back({3'($urandom_range(0, 7)), 5'(t)});
        end
        hdr = {3'($urandom_range(0, 7)), 5'($urandom_range(NAL_TYPE_LO, NAL_TYPE_HI))};
        if (kind < 15) begin
            if (mp_eff <= 40 && $urandom_range(0, 3) == 0) begin
                nal_len = mp_eff + $urandom_range(0, 1);
            end else begin
                hi = (mp_eff < 14) ? 3 * mp_eff + 2 : 40;
                nal_len = $urandom_range(2, hi);
            end
            push_start_code();
            hdr_at = fr.size();
            fr.push_back(hdr);
            repeat (nal_len - 1) fr.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 17) begin
            // start code too close to the end of the frame
            push_start_code();
            fr.push_back(hdr);
        end else begin
            repeat ($urandom_range(1, 8)) fr.push_back(junk_byte());
        end
    endtask

    // the length tag only matters in the search phase: elsewhere it gets noise
    task automatic send_frame(input logic noisy);
        int          n_bytes;
        logic [16:0] tag;
        n_bytes = fr.size();
        for (int i = 0; i < n_bytes; i++) begin
            tag = 17'(n_bytes);
            if (noisy && $urandom_range(0, 2) == 0) begin
                if (hdr_at >= 0 && i > hdr_at)
                    tag = 17'($urandom_range(0, FB_FIELD_MAX));
                else if (hdr_at < 0 && i == n_bytes - 1)
                    tag = 17'($urandom_range(0, n_bytes));
                else if (i != hdr_at)
                    tag = 17'($urandom_range(i + 2, FB_FIELD_MAX));
            end
            send_byte(fr[i], tag);
        end
    endtask

    initial begin
        int mp_raw, step, ptype, phase_end;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00, 17'd0);                        // one-byte frame, zero length tag
        load_hex(32'h0000_0165, 4, -1);                 // start code leaves too few bytes
        send_frame(1'b0);
        load_hex(40'h0000_0165_AA, 5, 3);               // shortest single packet
        send_frame(1'b0);
        load_hex(80'h0000_017C_0000_01E1_FF00, 10, 7);  // skipped type, then a hit
        send_frame(1'b0);

        // payload limit below range acts as 3: one byte per fragment
        drain_results();
        repeat (HOLD_OFF) @(posedge i_clk);
        write_regs(0, 90000, 127);
        load_hex(56'h0000_0117_5A3C_7E, 7, 3);
        send_frame(1'b0);

        for (int p = 2; p < NUM_PHASES; p++) begin
            case (p)
                2: begin
                    mp_raw = 4095; step = FB_FIELD_MAX; ptype = 0;
                end
                3: begin
                    mp_raw = 3; step = 0; ptype = 1;
                end
                NUM_PHASES - 1: begin
                    mp_raw = 2048; step = 90000; ptype = 64;
                end
                default: begin
                    mp_raw = $urandom_range(4, 24);
                    step   = $urandom_range(0, 90000);
                    ptype  = $urandom_range(0, 127);
                end
            endcase
            drain_results();
            repeat (HOLD_OFF) @(posedge i_clk);
            write_regs(mp_raw, step, ptype);
            phase_end = items_sent + (ITEMS_TOTAL - items_sent) / (NUM_PHASES - p);
            while (items_sent < phase_end) begin
                random_frame();
                send_frame(1'b1);
                if ($urandom_range(0, 11) == 0) drain_results();
            end
        end

        drain_results();
        repeat (HOLD_OFF) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
